>>> rtl/vlmq_pkg.sv
`timescale 1ns / 1ps
package vlmq_pkg;

    // Ring geometry
    localparam int CAPACITY    = 8192;
    localparam int MAX_MSG     = 2048;
    localparam int HDR_LEN     = 2;
    localparam int MAX_PAYLOAD = MAX_MSG - HDR_LEN;
    localparam int START_LIMIT = CAPACITY - 1 - MAX_MSG;

    // Field and state widths
    localparam int POS_W     = $clog2(CAPACITY);
    localparam int USED_W    = $clog2(CAPACITY) + 1;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 12;
    localparam int OUT_LEN_W = 11;
    localparam int CNT_W     = 12;
    localparam int ST_W      = 3;
    localparam int HDR_W     = 2 * BYTE_W;

    // Item modes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEN = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_ROOM = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [ST_W-1:0] ST_DROP    = 3'd4;

    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [BYTE_W-1:0]    data_out;
        logic [OUT_LEN_W-1:0] out_len;
        logic                 last;
        logic [CNT_W-1:0]     msg_count;
    } t_res;

    typedef struct packed {
        logic              we;
        t_pos              addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

    // Next ring position with wrap
    function automatic t_pos pos_inc(input t_pos p);
        t_pos r;
        if (p == t_pos'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = p + t_pos'(1);
        end
        return r;
    endfunction

    // A message never starts within MAX_MSG bytes of the ring end
    function automatic t_pos start_pos(input t_pos p);
        t_pos r;
        if (p > t_pos'(START_LIMIT)) begin
            r = '0;
        end else begin
            r = p;
        end
        return r;
    endfunction

endpackage

>>> rtl/vlmq_in_if.sv
`timescale 1ns / 1ps
interface vlmq_in_if;
    import vlmq_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  msg_len;

    modport source (output valid, output mode, output data_byte, output msg_len, input ready);
    modport sink   (input valid, input mode, input data_byte, input msg_len, output ready);
endinterface

>>> rtl/vlmq_out_if.sv
`timescale 1ns / 1ps
interface vlmq_out_if;
    import vlmq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [BYTE_W-1:0]    data_out;
    logic [OUT_LEN_W-1:0] out_len;
    logic                 last;
    logic [CNT_W-1:0]     msg_count;

    modport source (output valid, output status, output data_out, output out_len,
                    output last, output msg_count, input ready);
    modport sink   (input valid, input status, input data_out, input out_len,
                    input last, input msg_count, output ready);
endinterface

>>> rtl/vlmq_ram.sv
`timescale 1ns / 1ps
module vlmq_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/vlmq_ctrl.sv
`timescale 1ns / 1ps
module vlmq_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    vlmq_in_if.sink                        i_in,
    input  logic                           i_take,
    output vlmq_pkg::t_res                 o_res,
    output logic                           o_res_pend,
    output vlmq_pkg::t_mem_req             o_mem,
    input  logic [vlmq_pkg::BYTE_W-1:0]    i_rdata
);
    import vlmq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_H1   = 3'd1;  // header high byte
    localparam logic [2:0] S_H2   = 3'd2;  // first payload byte
    localparam logic [2:0] S_R0   = 3'd3;  // header low byte back
    localparam logic [2:0] S_R1   = 3'd4;  // header high byte back
    localparam logic [2:0] S_RD   = 3'd5;  // payload byte back

    logic [2:0]           r_state, n_state;
    t_pos                 r_wp, n_wp;
    t_pos                 r_rp, n_rp;
    t_pos                 r_addr, n_addr;
    logic [USED_W-1:0]    r_used, n_used;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [LEN_W-1:0]     r_push_rem, n_push_rem;
    logic                 r_push_drop, n_push_drop;
    logic [OUT_LEN_W-1:0] r_pop_rem, n_pop_rem;
    logic [OUT_LEN_W-1:0] r_pop_len, n_pop_len;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [BYTE_W-1:0]    r_lo, n_lo;
    t_res                 r_res, n_res;
    logic                 r_res_pend, n_res_pend;

    logic                 w_acc;
    logic                 w_bad_len;
    logic                 w_no_room;
    logic [HDR_W-1:0]     w_hdr;
    logic [OUT_LEN_W-1:0] w_hdr_len;
    logic [USED_W-1:0]    w_rel;
    t_pos                 w_wstart;
    t_pos                 w_rstart;

    assign i_in.ready = (r_state == S_IDLE) && (!r_res_pend || i_take);
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_bad_len = (i_in.msg_len == '0) || (i_in.msg_len > LEN_W'(MAX_PAYLOAD));
    assign w_no_room = ({1'b0, r_used} + (USED_W+1)'(2 * MAX_MSG)) > (USED_W+1)'(CAPACITY);
    assign w_wstart  = start_pos(r_wp);
    assign w_rstart  = start_pos(r_rp);
    assign w_rel     = USED_W'(HDR_LEN) + USED_W'(r_pop_len);

    // Stored header clamped to a legal length
    assign w_hdr = {i_rdata, r_lo};
    always_comb begin
        if (w_hdr == '0) begin
            w_hdr_len = OUT_LEN_W'(1);
        end else if (w_hdr > HDR_W'(MAX_PAYLOAD)) begin
            w_hdr_len = OUT_LEN_W'(MAX_PAYLOAD);
        end else begin
            w_hdr_len = w_hdr[OUT_LEN_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_addr      = r_addr;
        n_used      = r_used;
        n_count     = r_count;
        n_push_rem  = r_push_rem;
        n_push_drop = r_push_drop;
        n_pop_rem   = r_pop_rem;
        n_pop_len   = r_pop_len;
        n_byte      = r_byte;
        n_len       = r_len;
        n_lo        = r_lo;
        n_res       = r_res;
        n_res_pend  = r_res_pend && !i_take;
        o_mem       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_byte = i_in.data_byte;
                    n_len  = i_in.msg_len;
                    n_res  = '0;
                    if (i_in.mode == MODE_PUSH) begin
                        if (r_push_rem != '0) begin
                            if (r_push_drop) begin
                                n_res.status = ST_DROP;
                            end else begin
                                o_mem.we     = 1'b1;
                                o_mem.addr   = r_wp;
                                o_mem.wdata  = i_in.data_byte;
                                n_wp         = pos_inc(r_wp);
                                n_res.status = ST_OK;
                            end
                            n_push_rem = r_push_rem - LEN_W'(1);
                            if (r_push_rem == LEN_W'(1)) begin
                                n_res.last  = 1'b1;
                                n_push_drop = 1'b0;
                                if (!r_push_drop) begin
                                    n_count = r_count + CNT_W'(1);
                                end
                            end
                            n_res.msg_count = n_count;
                            n_res_pend      = 1'b1;
                        end else if (w_bad_len || w_no_room) begin
                            n_res.status    = w_bad_len ? ST_BAD_LEN : ST_NO_ROOM;
                            n_push_rem      = (i_in.msg_len == '0) ? '0
                                            : i_in.msg_len - LEN_W'(1);
                            n_push_drop     = i_in.msg_len > LEN_W'(1);
                            n_res.last      = i_in.msg_len == LEN_W'(1);
                            n_res.msg_count = r_count;
                            n_res_pend      = 1'b1;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.addr  = w_wstart;
                            o_mem.wdata = i_in.msg_len[BYTE_W-1:0];
                            n_addr      = pos_inc(w_wstart);
                            n_used      = r_used + USED_W'(HDR_LEN) + USED_W'(i_in.msg_len);
                            n_push_rem  = i_in.msg_len - LEN_W'(1);
                            n_push_drop = 1'b0;
                            if (i_in.msg_len == LEN_W'(1)) begin
                                n_count = r_count + CNT_W'(1);
                            end
                            n_state = S_H1;
                        end
                    end else begin
                        if (r_pop_rem == '0) begin
                            if (r_count == '0) begin
                                n_res.status    = ST_EMPTY;
                                n_res.msg_count = r_count;
                                n_res_pend      = 1'b1;
                            end else begin
                                o_mem.addr = w_rstart;
                                n_addr     = pos_inc(w_rstart);
                                n_state    = S_R0;
                            end
                        end else begin
                            o_mem.addr = r_rp;
                            n_state    = S_RD;
                        end
                    end
                end
            end
            S_H1: begin
                o_mem.we    = 1'b1;
                o_mem.addr  = r_addr;
                o_mem.wdata = BYTE_W'(r_len >> BYTE_W);
                n_addr      = pos_inc(r_addr);
                n_state     = S_H2;
            end
            S_H2: begin
                o_mem.we        = 1'b1;
                o_mem.addr      = r_addr;
                o_mem.wdata     = r_byte;
                n_wp            = pos_inc(r_addr);
                n_res           = '0;
                n_res.status    = ST_OK;
                n_res.last      = r_push_rem == '0;
                n_res.msg_count = r_count;
                n_res_pend      = 1'b1;
                n_state         = S_IDLE;
            end
            S_R0: begin
                n_lo       = i_rdata;
                o_mem.addr = r_addr;
                n_addr     = pos_inc(r_addr);
                n_state    = S_R1;
            end
            S_R1: begin
                n_pop_len  = w_hdr_len;
                n_pop_rem  = w_hdr_len;
                o_mem.addr = r_addr;
                n_rp       = r_addr;
                n_state    = S_RD;
            end
            S_RD: begin
                n_res          = '0;
                n_res.status   = ST_OK;
                n_res.data_out = i_rdata;
                n_res.out_len  = r_pop_len;
                n_rp           = pos_inc(r_rp);
                n_pop_rem      = r_pop_rem - OUT_LEN_W'(1);
                if (r_pop_rem == OUT_LEN_W'(1)) begin
                    n_res.last = 1'b1;
                    n_used     = (r_used >= w_rel) ? r_used - w_rel : '0;
                    if (r_count != '0) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                n_res.msg_count = n_count;
                n_res_pend      = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_push_rem  <= '0;
            r_push_drop <= 1'b0;
            r_pop_rem   <= '0;
            r_pop_len   <= '0;
            r_res_pend  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_used      <= n_used;
            r_count     <= n_count;
            r_push_rem  <= n_push_rem;
            r_push_drop <= n_push_drop;
            r_pop_rem   <= n_pop_rem;
            r_pop_len   <= n_pop_len;
            r_res_pend  <= n_res_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_byte <= n_byte;
        r_len  <= n_len;
        r_lo   <= n_lo;
        r_res  <= n_res;
    end

    assign o_res      = r_res;
    assign o_res_pend = r_res_pend;

    // A held result is never overwritten before it is taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_pend && !i_take) |=> (r_res_pend && $stable(r_res)))
        else $error("pending result overwritten");

    // Pop sequence never writes the ring
    a_pop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R0 || r_state == S_R1 || r_state == S_RD) |-> !o_mem.we)
        else $error("ring write during pop");

    a_drop_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_push_drop |-> (r_push_rem != '0))
        else $error("drop flag without bytes left");

    a_pop_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pop_rem <= r_pop_len)
        else $error("pop count beyond message length");

    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(CAPACITY))
        else $error("ring overfilled");
endmodule

>>> rtl/variable_length_message_ring_queue.sv
`timescale 1ns / 1ps
// Variable-length message ring queue.
// Input channel i_in: one item per payload byte (mode 0) or per pop (mode 1).
// The first push item of a message carries msg_len; the message is stored as
// a 2-byte length header plus payload in an 8-bit single-port ring RAM.
// Output channel o_out: exactly one result item per input item, in order,
// with status, popped byte, message length, last flag and message count.
// Steps per item, set by the single RAM port (one access per cycle):
//   push, mid-message or dropped byte: the byte is written or dropped on acceptance
//   push, message start: header low, header high, payload byte
//   pop, mid-message: payload read, then the byte taken from the registered RAM output
//   pop, message start: two header reads, then the payload read
// o_out.valid rises once the output register takes the result from the
// result register, which loads before the output register.
// Reset clears all position, count and message state at once; the RAM needs
// no clearing pass, since only written entries are ever read.
// A stalled receiver holds the output register; one more finished result
// waits inside, after which i_in.ready stays low until o_out.ready returns.
module variable_length_message_ring_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vlmq_in_if.sink    i_in,
    vlmq_out_if.source o_out
);
    import vlmq_pkg::*;

    t_mem_req          w_mem;
    logic [BYTE_W-1:0] w_rdata;
    t_res              w_res;
    logic              w_res_pend;
    logic              w_take;

    logic              r_out_valid;
    t_res              r_out;

    // Output slot is free when empty or being drained this cycle
    assign w_take = !r_out_valid || o_out.ready;

    vlmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_take     (w_take),
        .o_res      (w_res),
        .o_res_pend (w_res_pend),
        .o_mem      (w_mem),
        .i_rdata    (w_rdata)
    );

    vlmq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_addr  (w_mem.addr),
        .i_wdata (w_mem.wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_pend && w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_pend && w_take) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out.status;
    assign o_out.data_out  = r_out.data_out;
    assign o_out.out_len   = r_out.out_len;
    assign o_out.last      = r_out.last;
    assign o_out.msg_count = r_out.msg_count;
endmodule
